>>> rtl/fci_pkg.sv
`default_nettype none
package fci_pkg;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [11:0] word_addr;
        logic [15:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [15:0] read_data;
        logic [1:0]  lane_busy;
    } t_out_item;

    typedef enum logic [1:0] {
        MODE_READ  = 2'd0,
        MODE_ID    = 2'd1,
        MODE_PROG  = 2'd2,
        MODE_ERASE = 2'd3
    } t_mode;

    localparam logic [1:0] REQ_READ  = 2'd0;
    localparam logic [1:0] REQ_WRITE = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    localparam logic [1:0] CFG_BUSY_TICKS = 2'd0;
    localparam logic [1:0] CFG_VENDOR     = 2'd1;
    localparam logic [1:0] CFG_DEVICE     = 2'd2;

    localparam logic [15:0] RST_BUSY_TICKS = 16'd16;
    localparam logic [7:0]  RST_VENDOR     = 8'h04;
    localparam logic [7:0]  RST_DEVICE     = 8'hD4;

    localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
    localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
    localparam logic [7:0] CMD_ERASE   = 8'h80;
    localparam logic [7:0] CMD_SECTOR  = 8'h30;
    localparam logic [7:0] CMD_PROGRAM = 8'hA0;
    localparam logic [7:0] CMD_ID      = 8'h90;
    localparam logic [7:0] CMD_RESET   = 8'hF0;

    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_UNL1   = 3'd1;
    localparam logic [2:0] PH_UNL2   = 3'd2;
    localparam logic [2:0] PH_ER_UN1 = 3'd3;
    localparam logic [2:0] PH_ER_UN2 = 3'd4;
    localparam logic [2:0] PH_ER_CMD = 3'd5;
    localparam logic [2:0] PH_PDATA  = 3'd6;

    // controller -> datapath
    typedef struct packed {
        logic clr_we;
        logic accept;
        logic rd_req;      // read array at request address
        logic rd_target;   // read array at a lane's target word
        logic lane_sel;
        logic read_resp;
        logic lane_write;
        logic tick;
        logic fin;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       clr_last;
        logic       out_free;  // output register can take a result this cycle
        logic [1:0] req_type;
    } t_status;

endpackage
`default_nettype wire

>>> rtl/fci_lane.sv
`default_nettype none
module fci_lane
    import fci_pkg::*;
#(
    parameter int ADDR_BITS = 12,
    parameter int SECTOR_BITS = 8
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_wr_en,
    input  wire logic [7:0]           i_wr_byte,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    input  wire logic                 i_rd_en,
    input  wire logic                 i_tick_en,
    input  wire logic [7:0]           i_mem_byte,
    input  wire logic [15:0]          i_busy_ticks,
    output t_mode                     o_mode,
    output logic [ADDR_BITS-1:0]      o_target,
    output logic [7:0]                o_status,
    output logic                      o_mem_we,
    output logic [7:0]                o_mem_byte
);

    localparam int SB = (SECTOR_BITS < ADDR_BITS) ? SECTOR_BITS : ADDR_BITS;
    localparam logic [ADDR_BITS-1:0] SMASK = ADDR_BITS'((64'd1 << SB) - 64'd1);

    t_mode                r_mode, n_mode;
    logic [2:0]           r_phase, n_phase;
    logic [15:0]          r_busy, n_busy;
    logic                 r_toggle, n_toggle;
    logic [ADDR_BITS-1:0] r_target, n_target;
    logic [7:0]           r_pbyte, n_pbyte;
    logic [ADDR_BITS-1:0] w_next_t;

    assign w_next_t = r_target + ADDR_BITS'(1);

    always_comb begin
        n_mode     = r_mode;
        n_phase    = r_phase;
        n_busy     = r_busy;
        n_toggle   = r_toggle;
        n_target   = r_target;
        n_pbyte    = r_pbyte;
        o_mem_we   = 1'b0;
        o_mem_byte = 8'hFF;
        if (i_wr_en && (r_mode == MODE_READ || r_mode == MODE_ID)) begin
            if (r_phase == PH_PDATA) begin
                n_pbyte  = i_wr_byte;
                n_target = i_addr;
                n_busy   = (i_busy_ticks == 16'd0) ? 16'd1 : i_busy_ticks;
                n_mode   = MODE_PROG;
                n_phase  = PH_IDLE;
            end else if (i_wr_byte == CMD_RESET) begin
                n_mode  = MODE_READ;
                n_phase = PH_IDLE;
            end else begin
                n_phase = PH_IDLE;
                unique case (r_phase)
                    PH_IDLE:   if (i_wr_byte == CMD_UNLOCK1) n_phase = PH_UNL1;
                    PH_UNL1:   if (i_wr_byte == CMD_UNLOCK2) n_phase = PH_UNL2;
                    PH_UNL2: begin
                        if (i_wr_byte == CMD_ERASE) n_phase = PH_ER_UN1;
                        else if (i_wr_byte == CMD_PROGRAM) n_phase = PH_PDATA;
                        else if (i_wr_byte == CMD_ID) n_mode = MODE_ID;
                    end
                    PH_ER_UN1: if (i_wr_byte == CMD_UNLOCK1) n_phase = PH_ER_UN2;
                    PH_ER_UN2: if (i_wr_byte == CMD_UNLOCK2) n_phase = PH_ER_CMD;
                    PH_ER_CMD: begin
                        if (i_wr_byte == CMD_SECTOR) begin
                            n_target = i_addr & ~SMASK;
                            n_mode   = MODE_ERASE;
                        end
                    end
                    default:   n_phase = PH_IDLE;
                endcase
            end
        end
        if (i_rd_en && (r_mode == MODE_PROG || r_mode == MODE_ERASE)) begin
            n_toggle = ~r_toggle;
        end
        if (i_tick_en) begin
            if (r_mode == MODE_PROG) begin
                if (r_busy <= 16'd1) begin
                    n_busy     = 16'd0;
                    o_mem_we   = 1'b1;
                    o_mem_byte = i_mem_byte & r_pbyte;
                    n_mode     = MODE_READ;
                end else begin
                    n_busy = r_busy - 16'd1;
                end
            end else if (r_mode == MODE_ERASE) begin
                o_mem_we   = 1'b1;
                o_mem_byte = 8'hFF;
                n_target   = w_next_t;
                if ((w_next_t & SMASK) == '0) n_mode = MODE_READ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_READ;
            r_phase  <= PH_IDLE;
            r_busy   <= '0;
            r_toggle <= 1'b0;
            r_target <= '0;
            r_pbyte  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_phase  <= n_phase;
            r_busy   <= n_busy;
            r_toggle <= n_toggle;
            r_target <= n_target;
            r_pbyte  <= n_pbyte;
        end
    end

    assign o_mode   = r_mode;
    assign o_target = r_target;
    // DQ7 = ~data bit 7 (erase data is all ones), DQ6 toggles per read
    assign o_status = {(r_mode == MODE_PROG) ? ~r_pbyte[7] : 1'b0, r_toggle, 6'b0};

endmodule
`default_nettype wire

>>> rtl/fci_datapath.sv
`default_nettype none
module fci_datapath
    import fci_pkg::*;
#(
    parameter int ADDR_BITS = 12,
    parameter int SECTOR_BITS = 8
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire t_cmd       i_cmd,
    output t_status         o_status,
    input  wire t_in_item   i_in,
    output t_out_item       o_out,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    input  wire logic       i_cfg_valid,
    input  wire logic [1:0] i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    localparam int WORDS = 1 << ADDR_BITS;

    logic [15:0]          mem [WORDS];
    logic [15:0]          r_rdata;
    logic [ADDR_BITS-1:0] r_clr_cnt;
    logic [1:0]           r_req;
    logic [ADDR_BITS-1:0] r_addr;
    logic [15:0]          r_wdata;
    logic [15:0]          r_rdw;
    logic [15:0]          r_busy_ticks;
    logic [7:0]           r_vendor;
    logic [7:0]           r_device;
    t_out_item            r_out;
    logic                 r_out_valid;

    t_mode                w_mode [2];
    logic [ADDR_BITS-1:0] w_target [2];
    logic [7:0]           w_stat [2];
    logic [1:0]           w_mwe;
    logic [7:0]           w_mbyte [2];
    logic [1:0]           w_busy;
    logic [7:0]           w_rbyte [2];

    logic                 w_we;
    logic [1:0]           w_be;
    logic [ADDR_BITS-1:0] w_waddr;
    logic [15:0]          w_wword;
    logic [ADDR_BITS-1:0] w_raddr;

    for (genvar l = 0; l < 2; l++) begin : g_lane
        fci_lane #(
            .ADDR_BITS(ADDR_BITS),
            .SECTOR_BITS(SECTOR_BITS)
        ) u_lane (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_wr_en     (i_cmd.lane_write),
            .i_wr_byte   (r_wdata[8*l +: 8]),
            .i_addr      (r_addr),
            .i_rd_en     (i_cmd.read_resp),
            .i_tick_en   (i_cmd.tick && (i_cmd.lane_sel == 1'(l))),
            .i_mem_byte  (r_rdata[8*l +: 8]),
            .i_busy_ticks(r_busy_ticks),
            .o_mode      (w_mode[l]),
            .o_target    (w_target[l]),
            .o_status    (w_stat[l]),
            .o_mem_we    (w_mwe[l]),
            .o_mem_byte  (w_mbyte[l])
        );
        assign w_busy[l] = (w_mode[l] == MODE_PROG) || (w_mode[l] == MODE_ERASE);
        assign w_rbyte[l] = w_busy[l] ? w_stat[l] :
                            (w_mode[l] == MODE_ID) ? (r_addr[0] ? r_device : r_vendor) :
                            r_rdata[8*l +: 8];
    end

    always_comb begin
        w_we    = 1'b0;
        w_be    = 2'b00;
        w_waddr = w_target[i_cmd.lane_sel];
        w_wword = {w_mbyte[1], w_mbyte[0]};
        if (i_cmd.clr_we) begin
            w_we    = 1'b1;
            w_be    = 2'b11;
            w_waddr = r_clr_cnt;
            w_wword = 16'hFFFF;
        end else if (w_mwe != 2'b00) begin
            w_we = 1'b1;
            w_be = w_mwe;
        end
        w_raddr = i_cmd.rd_target ? w_target[i_cmd.lane_sel] : r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            if (w_be[0]) mem[w_waddr][7:0] <= w_wword[7:0];
            if (w_be[1]) mem[w_waddr][15:8] <= w_wword[15:8];
        end
        if (i_cmd.rd_req || i_cmd.rd_target) begin
            r_rdata <= mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req   <= i_in.req_type;
            r_addr  <= ADDR_BITS'(i_in.word_addr);
            r_wdata <= i_in.write_data;
            r_rdw   <= '0;
        end else if (i_cmd.read_resp) begin
            r_rdw <= {w_rbyte[1], w_rbyte[0]};
        end
        if (i_cmd.fin) begin
            r_out.read_data <= r_rdw;
            r_out.lane_busy <= w_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_cnt    <= '0;
            r_out_valid  <= 1'b0;
            r_busy_ticks <= RST_BUSY_TICKS;
            r_vendor     <= RST_VENDOR;
            r_device     <= RST_DEVICE;
        end else begin
            if (i_cmd.clr_we) r_clr_cnt <= r_clr_cnt + ADDR_BITS'(1);
            if (i_cmd.fin) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_BUSY_TICKS: r_busy_ticks <= i_cfg_data;
                    CFG_VENDOR:     r_vendor <= i_cfg_data[7:0];
                    CFG_DEVICE:     r_device <= i_cfg_data[7:0];
                    default:        ;
                endcase
            end
        end
    end

    assign o_status.clr_last = (r_clr_cnt == '1);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.req_type = r_req;
    assign o_out             = r_out;
    assign o_out_valid       = r_out_valid;

endmodule
`default_nettype wire

>>> rtl/fci_ctrl.sv
`default_nettype none
module fci_ctrl
    import fci_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    output logic         o_in_ready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    typedef enum logic [9:0] {
        S_CLEAR = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_RD    = 10'b0000000100,
        S_RESP  = 10'b0000001000,
        S_WR    = 10'b0000010000,
        S_TRD0  = 10'b0000100000,
        S_TWR0  = 10'b0001000000,
        S_TRD1  = 10'b0010000000,
        S_TWR1  = 10'b0100000000,
        S_FIN   = 10'b1000000000
    } t_state;

    t_state r_state, n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_we = 1'b1;
                if (i_status.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (o_in_ready && i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_RD;
                end
            end
            S_RD: begin
                // request latched; dispatch on its type
                priority case (i_status.req_type)
                    REQ_READ: begin
                        o_cmd.rd_req = 1'b1;
                        n_state      = S_RESP;
                    end
                    REQ_WRITE: n_state = S_WR;
                    REQ_TICK:  n_state = S_TRD0;
                    default:   n_state = S_FIN;
                endcase
            end
            S_RESP: begin
                o_cmd.read_resp = 1'b1;
                n_state         = S_FIN;
            end
            S_WR: begin
                o_cmd.lane_write = 1'b1;
                n_state          = S_FIN;
            end
            S_TRD0: begin
                o_cmd.rd_target = 1'b1;
                n_state         = S_TWR0;
            end
            S_TWR0: begin
                o_cmd.tick = 1'b1;
                n_state    = S_TRD1;
            end
            S_TRD1: begin
                o_cmd.rd_target = 1'b1;
                o_cmd.lane_sel  = 1'b1;
                n_state         = S_TWR1;
            end
            S_TWR1: begin
                o_cmd.tick     = 1'b1;
                o_cmd.lane_sel = 1'b1;
                n_state        = S_FIN;
            end
            S_FIN: begin
                // hold until the output register is free
                if (i_status.out_free) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule
`default_nettype wire

>>> rtl/flash_command_interface_top.sv
// channel   signals                          direction
// in        i_in_valid / o_in_ready / i_in   request item in
// out       o_out_valid / i_out_ready / o_out result item out
// cfg       i_cfg_valid / o_cfg_ready,       register write in
//           i_cfg_index / i_cfg_data
// Read and write items go from the accept through S_RD, S_RESP or S_WR and
// S_FIN, which registers the result; ticks go through S_RD, S_TRD0, S_TWR0,
// S_TRD1, S_TWR1 and S_FIN (each lane reads then writes its target word on the
// single RAM). After reset all 2**ADDR_BITS words are swept to all ones with
// o_in_ready low; config writes are taken at any time.
// A new item may be taken while a result waits; the block stalls in S_FIN
// only while the output register is full and i_out_ready is low.
`default_nettype none
module flash_command_interface_top
    import fci_pkg::*;
#(
    parameter int ADDR_BITS = 12,
    parameter int SECTOR_BITS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [15:0] i_cfg_data
);

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    fci_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_status  (w_status),
        .o_cmd     (w_cmd)
    );

    fci_datapath #(
        .ADDR_BITS(ADDR_BITS),
        .SECTOR_BITS(SECTOR_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .i_cfg_valid(i_cfg_valid),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

endmodule
`default_nettype wire
